// ----- hw/rtl/srs_pkg.sv -----
// Shared widths, queue depth and command type for the stable rank sorter.
package srs_pkg;

	localparam int ALIGN_W     = 17;
	localparam int SIZE_W      = 32;
	localparam int POS_W       = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int GRP_SIZE    = 8;
	localparam int GRP_CNT_W   = 4;

	// One classified member as it travels from the front to the back
	typedef struct packed {
		logic [ALIGN_W-1:0] align;
		logic [SIZE_W-1:0]  size;
		logic               last;
		logic               drop;
	} srs_cmd_t;

endpackage

// ----- hw/rtl/srs_front.sv -----
// Front end: accepts members, tags each one as kept or dropped, pushes it to the queue.
module srs_front import srs_pkg::*; #(
	parameter int MAX_MEMBERS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ALIGN_W-1:0] member_alignment,
	input  logic [SIZE_W-1:0]  member_size,
	input  logic               last_member,
	input  logic               q_full,
	output logic               push,
	output srs_cmd_t           cmd
);

	localparam int CW = $clog2(MAX_MEMBERS + 1);

	logic [CW-1:0] count_q;
	logic          full_list;

	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;
	assign full_list = (count_q == CW'(MAX_MEMBERS));

	// classify the member
	always_comb begin
		cmd.align = member_alignment;
		cmd.size  = member_size;
		cmd.last  = last_member;
		cmd.drop  = full_list;
	end

	// members seen in the current list, saturating at capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (last_member) begin
				count_q <= '0;
			end else if (!full_list) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/srs_queue.sv -----
// Short command queue between the front end and the rank engine.
module srs_queue import srs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  srs_cmd_t push_cmd,
	output logic     full,
	output logic     pop_valid,
	input  logic     pop,
	output srs_cmd_t pop_cmd
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	srs_cmd_t      entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (fill_q == NW'(QUEUE_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/srs_back.sv -----
// Rank engine: a row of member cells that keep live ranks, and the result walk.
module srs_back import srs_pkg::*; #(
	parameter int MAX_MEMBERS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  srs_cmd_t         cmd,
	output logic             cmd_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [POS_W-1:0] new_position,
	output logic             last_position,
	output logic             overflow
);

	localparam int IW    = $clog2(MAX_MEMBERS);
	localparam int CW    = $clog2(MAX_MEMBERS + 1);
	localparam int NG    = (MAX_MEMBERS + GRP_SIZE - 1) / GRP_SIZE;
	localparam int PADW  = NG * GRP_SIZE;
	localparam int KEY_W = ALIGN_W + SIZE_W;

	typedef enum logic [1:0] {ST_LOAD, ST_DRAIN, ST_EMIT} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic                  ovf_q;
	logic [IW-1:0]         emit_q;
	logic                  out_valid_q;
	logic [POS_W-1:0]      new_position_q;
	logic                  last_position_q;
	logic                  overflow_q;

	logic [KEY_W-1:0]      key_q   [MAX_MEMBERS];
	logic [IW-1:0]         rank_q  [MAX_MEMBERS];
	logic [IW-1:0]         rank_nx [MAX_MEMBERS];

	logic                  valid_s1;
	logic [PADW-1:0]       ge_s1;
	logic [IW-1:0]         idx_s1;
	logic                  valid_s2;
	logic [GRP_CNT_W-1:0]  grp_s2 [NG];
	logic [IW-1:0]         idx_s2;

	logic [KEY_W-1:0]      new_key;
	logic [PADW-1:0]       ge_c;
	logic [GRP_CNT_W-1:0]  grp_c [NG];
	logic                  append;
	logic [CW-1:0]         sum_acc;
	logic [IW-1:0]         rank_sum;
	logic                  load_out;
	logic                  emit_last;
	logic [POS_W+IW-1:0]   pos_ext;

	assign new_key   = {cmd.align, cmd.size};
	assign cmd_pop   = (state_q == ST_LOAD) && cmd_valid;
	assign append    = cmd_pop && !cmd.drop;
	assign load_out  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last = (CW'(emit_q) + CW'(1) == count_q);
	assign pos_ext   = {{POS_W{1'b0}}, rank_q[emit_q]};

	assign out_valid     = out_valid_q;
	assign new_position  = new_position_q;
	assign last_position = last_position_q;
	assign overflow      = overflow_q;

	// compare the new member against every stored cell: cell sorts ahead on >=
	always_comb begin
		ge_c = '0;
		for (int k = 0; k < MAX_MEMBERS; k++) begin
			ge_c[k] = (CW'(k) < count_q) && (key_q[k] >= new_key);
		end
	end

	// population count of each group of registered compare bits
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_c[g] = '0;
			for (int b = 0; b < GRP_SIZE; b++) begin
				grp_c[g] = grp_c[g] + GRP_CNT_W'(ge_s1[g * GRP_SIZE + b]);
			end
		end
	end

	// adder over the registered group counts gives the new member's rank
	always_comb begin
		sum_acc = '0;
		for (int g = 0; g < NG; g++) begin
			sum_acc = sum_acc + CW'(grp_s2[g]);
		end
		rank_sum = sum_acc[IW-1:0];
	end

	// rank update: fresh rank lands at stage 2, older cells bump at stage 1
	always_comb begin
		for (int k = 0; k < MAX_MEMBERS; k++) begin
			rank_nx[k] = (valid_s2 && (idx_s2 == IW'(k))) ? rank_sum : rank_q[k];
			if (valid_s1 && (IW'(k) < idx_s1) && !ge_s1[k]) begin
				rank_nx[k] = rank_nx[k] + IW'(1);
			end
		end
	end

	// cell keys, ranks and compare pipeline
	always_ff @(posedge clk) begin
		if (append) begin
			key_q[count_q[IW-1:0]] <= new_key;
		end
		ge_s1  <= ge_c;
		idx_s1 <= count_q[IW-1:0];
		for (int g = 0; g < NG; g++) begin
			grp_s2[g] <= grp_c[g];
		end
		idx_s2 <= idx_s1;
		for (int k = 0; k < MAX_MEMBERS; k++) begin
			rank_q[k] <= rank_nx[k];
		end
	end

	// sequencer: load members, drain the rank pipe, walk the results out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_LOAD;
			count_q         <= '0;
			ovf_q           <= 1'b0;
			emit_q          <= '0;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			out_valid_q     <= 1'b0;
			new_position_q  <= '0;
			last_position_q <= 1'b0;
			overflow_q      <= 1'b0;
		end else begin
			valid_s1 <= append;
			valid_s2 <= valid_s1;
			// result register: load a new transfer or clear once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (cmd_pop) begin
						if (append) begin
							count_q <= count_q + CW'(1);
						end
						if (cmd.drop) begin
							ovf_q <= 1'b1;
						end
						if (cmd.last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						new_position_q  <= pos_ext[POS_W-1:0];
						last_position_q <= emit_last;
						overflow_q      <= ovf_q;
						if (emit_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							emit_q <= emit_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// checks
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_MEMBERS))
		else $error("member count above capacity");

	a_pipe_empty_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (!valid_s1 && !valid_s2))
		else $error("result walk started with ranks still in flight");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (count_q != '0))
		else $error("result walk over an empty list");

	a_run_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && emit_last) |=> (count_q == '0 && !ovf_q && state_q == ST_LOAD))
		else $error("list state not cleared after final result");

endmodule

// ----- hw/rtl/stable_rank_sort_by_align_size.sv -----
// Top level: stable descending rank of members by alignment, then size.
// Members transfer at one per cycle while the queue is not full; the front tags them and a
// 4-entry queue feeds the rank cells. Each member is compared with all stored cells at once
// and its rank is built by the compare pipe. After the last member leaves the queue, the walk
// over the rank cells gives one result per cycle unless stalled (n results for n kept members).
// Reset (arst_n low, asynchronous) clears counts, queue and flags; stored members are not cleared.
module stable_rank_sort_by_align_size import srs_pkg::*; #(
	parameter int MAX_MEMBERS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ALIGN_W-1:0] member_alignment,
	input  logic [SIZE_W-1:0]  member_size,
	input  logic               last_member,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [POS_W-1:0]   new_position,
	output logic               last_position,
	output logic               overflow
);

	logic     q_full;
	logic     push;
	srs_cmd_t push_cmd;
	logic     pop_valid;
	logic     pop;
	srs_cmd_t pop_cmd;

	srs_front #(.MAX_MEMBERS(MAX_MEMBERS)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.member_alignment (member_alignment),
		.member_size      (member_size),
		.last_member      (last_member),
		.q_full           (q_full),
		.push             (push),
		.cmd              (push_cmd)
	);

	srs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_cmd   (pop_cmd)
	);

	srs_back #(.MAX_MEMBERS(MAX_MEMBERS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (pop_valid),
		.cmd           (pop_cmd),
		.cmd_pop       (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.new_position  (new_position),
		.last_position (last_position),
		.overflow      (overflow)
	);

endmodule

// ----- dv/stable_rank_sort_by_align_size_tb.sv -----
// Testbench for the stable rank sorter: directed and random member lists, checked per result.
`timescale 1ns / 1ps

module stable_rank_sort_by_align_size_tb;
	import srs_pkg::*;

	localparam int MAX_MEMBERS = 32;
	localparam int DRAIN_CYCLES = 40;

	// One expected result of a sorted list
	typedef struct {
		logic [POS_W-1:0] position;
		logic             final_pos;
		logic             dropped;
	} rank_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [ALIGN_W-1:0] member_alignment;
	logic [SIZE_W-1:0]  member_size;
	logic               last_member;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [POS_W-1:0]   new_position;
	logic               last_position;
	logic               overflow;

	// Shadow copy of the list being collected, and results still owed
	logic [ALIGN_W-1:0] list_align[$];
	logic [SIZE_W-1:0]  list_size[$];
	bit                 list_dropped;
	rank_result_t       expected_ranks[$];

	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;

	stable_rank_sort_by_align_size #(
		.MAX_MEMBERS(MAX_MEMBERS)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.member_alignment (member_alignment),
		.member_size      (member_size),
		.last_member      (last_member),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.new_position     (new_position),
		.last_position    (last_position),
		.overflow         (overflow)
	);

	always #4 clk = ~clk;

	// True if stored member j lands ahead of member i in the stable sort
	function automatic bit outranks(int j, int i);
		if (list_align[j] != list_align[i])
			return list_align[j] > list_align[i];
		if (list_size[j] != list_size[i])
			return list_size[j] > list_size[i];
		return j < i;
	endfunction

	// Track one accepted member; on the last mark, rank the whole list
	task automatic record_member(input logic [ALIGN_W-1:0] a, input logic [SIZE_W-1:0] s,
			input logic last);
		int n;
		int pos;
		rank_result_t r;
		if (list_align.size() < MAX_MEMBERS) begin
			list_align.push_back(a);
			list_size.push_back(s);
		end else begin
			list_dropped = 1'b1;
		end
		if (!last)
			return;
		n = list_align.size();
		for (int i = 0; i < n; i++) begin
			pos = 0;
			for (int j = 0; j < n; j++)
				if (j != i && outranks(j, i))
					pos++;
			r.position  = pos[POS_W-1:0];
			r.final_pos = (i == n - 1);
			r.dropped   = list_dropped;
			expected_ranks.push_back(r);
		end
		list_align.delete();
		list_size.delete();
		list_dropped = 1'b0;
	endtask

	// Present one member, with random idle cycles ahead of it, and wait for the transfer
	task automatic send_member(input logic [ALIGN_W-1:0] a, input logic [SIZE_W-1:0] s,
			input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		member_alignment <= a;
		member_size      <= s;
		last_member      <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		record_member(a, s, last);
	endtask

	// Alignments lean on powers of two so that ties are common
	function automatic logic [ALIGN_W-1:0] pick_alignment();
		case ($urandom_range(3))
			0: return ALIGN_W'($urandom);
			1, 2: return ALIGN_W'(1) << $urandom_range(0, 16);
			default: return ($urandom_range(1)) ? ALIGN_W'(4) : ALIGN_W'(8);
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(3))
			0: return $urandom;
			1: return SIZE_W'($urandom_range(0, 3) * 8);
			2: return SIZE_W'($urandom_range(0, 2) * 4);
			default: return ($urandom_range(1)) ? '1 : '0;
		endcase
	endfunction

	// A list of random members, last mark on the final one
	task automatic send_list(input int len);
		for (int k = 0; k < len; k++)
			send_member(pick_alignment(), pick_size(), k == len - 1);
	endtask

	// Extremes of both keys, including out-of-range alignments
	task automatic test_extremes();
		send_member(17'h1FFFF, 32'hFFFFFFFF, 1'b0);
		send_member(17'h00000, 32'h00000000, 1'b0);
		send_member(17'h00001, 32'hFFFFFFFF, 1'b0);
		send_member(17'h10000, 32'h00000000, 1'b0);
		send_member(17'h10000, 32'hFFFFFFFF, 1'b0);
		send_member(17'h00001, 32'h00000000, 1'b0);
		send_member(17'h00000, 32'hFFFFFFFF, 1'b0);
		send_member(17'h1FFFF, 32'h00000000, 1'b1);
		send_member(17'h15555, 32'hAAAAAAAA, 1'b0);
		send_member(17'h0AAAA, 32'h55555555, 1'b1);
	endtask

	// Equal members must keep arrival order
	task automatic test_ties();
		send_member(17'd8, 32'd16, 1'b0);
		send_member(17'd8, 32'd16, 1'b0);
		send_member(17'd4, 32'd16, 1'b0);
		send_member(17'd8, 32'd16, 1'b0);
		send_member(17'd8, 32'd32, 1'b0);
		send_member(17'd8, 32'd16, 1'b1);
	endtask

	task automatic test_single_member();
		send_member(17'd64, 32'd100, 1'b1);
	endtask

	// Store filled exactly, no drop
	task automatic test_full_store();
		send_list(MAX_MEMBERS);
	endtask

	// Members past capacity are dropped; the last mark still closes the list
	task automatic test_overflow();
		send_list(MAX_MEMBERS + 1);
		send_list(MAX_MEMBERS + 8);
		send_list(3);
	endtask

	// Mostly short lists, a few long ones, the odd one past capacity
	task automatic test_random_lists(input int n_items);
		int sent;
		int len;
		int pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 70)
				len = $urandom_range(1, 6);
			else if (pick < 90)
				len = $urandom_range(7, 20);
			else if (pick < 96)
				len = $urandom_range(21, MAX_MEMBERS);
			else
				len = $urandom_range(MAX_MEMBERS + 1, MAX_MEMBERS + 8);
			send_list(len);
			sent += len;
		end
	endtask

	// Receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < receiver_idle_pct);

	// Compare every result transfer with the oldest expectation
	always @(posedge clk) begin
		rank_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ranks.size() == 0) begin
				$error("unexpected result: new_position %0d", new_position);
				mismatch_count++;
			end else begin
				exp_r = expected_ranks.pop_front();
				if (new_position !== exp_r.position) begin
					$error("new_position: expected %0d, actual %0d", exp_r.position,
						new_position);
					mismatch_count++;
				end
				if (last_position !== exp_r.final_pos) begin
					$error("last_position: expected %0b, actual %0b", exp_r.final_pos,
						last_position);
					mismatch_count++;
				end
				if (overflow !== exp_r.dropped) begin
					$error("overflow: expected %0b, actual %0b", exp_r.dropped, overflow);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		member_alignment <= '0;
		member_size      <= '0;
		last_member      <= 1'b0;
		list_dropped     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles lightly, receiver heavily
		sender_idle_pct   = 29;
		receiver_idle_pct = 63;
		test_extremes();
		test_ties();
		test_single_member();
		test_full_store();
		test_random_lists(60);

		// Roles swapped
		sender_idle_pct   = 63;
		receiver_idle_pct = 29;
		test_overflow();
		test_random_lists(65);

		// Full rate on both sides
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		test_random_lists(65);

		in_valid <= 1'b0;
		while (expected_ranks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_ranks.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/srs_pkg.sv
hw/rtl/srs_front.sv
hw/rtl/srs_queue.sv
hw/rtl/srs_back.sv
hw/rtl/stable_rank_sort_by_align_size.sv
dv/stable_rank_sort_by_align_size_tb.sv
